// File: rtl/rrc_pkg.sv
package rrc_pkg;

  localparam int FIELD_W = 25;
  localparam int CHAR_W  = 8;
  localparam int SIZE_W  = 9;
  localparam int CIDX_W  = 2;

  localparam logic [CHAR_W-1:0] TYPE_FILLED  = 8'h52;
  localparam logic [CHAR_W-1:0] TYPE_OUTLINE = 8'h72;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 9'd1;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 9'd1;
  localparam logic [CHAR_W-1:0] BG_RESET     = 8'd32;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_DRAW  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BG     = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_READ
  } state_t;

  typedef enum logic [1:0] {
    SW_CLEAR,
    SW_FILL,
    SW_OUTLINE
  } sweep_mode_t;

  typedef struct packed {
    logic        start;
    sweep_mode_t mode;
  } sweep_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_sts_t;

endpackage

// File: rtl/rrc_ifs.sv
interface rrc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic [rrc_pkg::CHAR_W-1:0]           shape_type;
  logic signed [rrc_pkg::FIELD_W-1:0]   rect_left;
  logic signed [rrc_pkg::FIELD_W-1:0]   rect_top;
  logic signed [rrc_pkg::FIELD_W-1:0]   rect_width;
  logic signed [rrc_pkg::FIELD_W-1:0]   rect_height;
  logic [rrc_pkg::CHAR_W-1:0]           paint_char;
  logic [7:0]                           read_col;
  logic [7:0]                           read_row;

  modport source (
    output valid, action, shape_type, rect_left, rect_top, rect_width, rect_height,
           paint_char, read_col, read_row,
    input  ready
  );
  modport sink (
    input  valid, action, shape_type, rect_left, rect_top, rect_width, rect_height,
           paint_char, read_col, read_row,
    output ready
  );
endinterface

interface rrc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic [rrc_pkg::CHAR_W-1:0] cell_char;

  modport source (output valid, status, cell_char, input ready);
  modport sink (input valid, status, cell_char, output ready);
endinterface

interface rrc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rrc_pkg::CIDX_W-1:0] index;
  logic [rrc_pkg::SIZE_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/rectangle_raster_canvas_unit.sv
// Rectangle raster canvas.
// req carries one action per beat: clear, draw rectangle or read one cell.
// rsp returns exactly one beat per request: status and cell_char.
// cfg writes canvas_width, canvas_height and background_char; ready is
// always high, and writes are meant for idle periods only.
// Clear and draw walk every cell in use through the single write port of the
// canvas memory, one cell per cycle, and answer when the sweep is done. An
// invalid draw and the unused action answer in the cycle after accept. A read
// goes through the registered memory read, then the response register.
// One request is in flight at a time; req.ready is high in idle while the
// response register is empty or being drained, so a stalled rsp holds the
// response and blocks the next request.
// rst clears control state and the registers to width 1, height 1,
// background 32. Canvas contents are undefined until the first clear.
module rectangle_raster_canvas_unit #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic   clk,
  input  logic   rst,
  rrc_req_if.sink   req,
  rrc_rsp_if.source rsp,
  rrc_cfg_if.sink   cfg
);
  import rrc_pkg::*;

  localparam int CNW   = $clog2(MAX_COLS + 1);
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CW    = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int RW    = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int AW    = CW + RW;
  localparam int CMPW  = 12;

  logic [SIZE_W-1:0]  canvas_width;
  logic [SIZE_W-1:0]  canvas_height;
  logic [CHAR_W-1:0]  background_char;

  state_t             state, state_next;
  logic               rd_ok;
  logic               rsp_valid;
  logic               rsp_status;
  logic [CHAR_W-1:0]  rsp_cell;

  logic [CNW-1:0]     cols;
  logic [RNW-1:0]     rows;
  logic               accept;
  logic               type_ok, draw_ok, draw_bad, immediate, is_sweep;
  logic               load_imm, load_read, load_sweep;
  sweep_ctl_t         sw_ctl;
  sweep_sts_t         sw_sts;
  logic [CHAR_W-1:0]  sw_chr;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [CHAR_W-1:0]  wr_data, rd_data;
  logic               rd_in_range;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= WIDTH_RESET;
      canvas_height   <= HEIGHT_RESET;
      background_char <= BG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WIDTH:  canvas_width    <= cfg.data;
        REG_HEIGHT: canvas_height   <= cfg.data;
        REG_BG:     background_char <= cfg.data[CHAR_W-1:0];
        default:    ;
      endcase
    end
  end

  assign cols = (CMPW'(canvas_width) > CMPW'(MAX_COLS)) ? CNW'(MAX_COLS)
                                                        : CNW'(canvas_width);
  assign rows = (CMPW'(canvas_height) > CMPW'(MAX_ROWS)) ? RNW'(MAX_ROWS)
                                                         : RNW'(canvas_height);

  assign req.ready = (state == ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign type_ok   = (req.shape_type == TYPE_FILLED) || (req.shape_type == TYPE_OUTLINE);
  assign draw_ok   = type_ok && (req.rect_width > 0) && (req.rect_height > 0);
  assign draw_bad  = (action_t'(req.action) == ACT_DRAW) && !draw_ok;
  assign is_sweep  = (action_t'(req.action) == ACT_CLEAR)
                  || ((action_t'(req.action) == ACT_DRAW) && draw_ok);
  assign immediate = (action_t'(req.action) == ACT_NONE) || draw_bad;

  assign rd_in_range = (CMPW'(req.read_col) < CMPW'(cols))
                    && (CMPW'(req.read_row) < CMPW'(rows));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_sweep) begin
          state_next = ST_SWEEP;
        end else if (accept && (action_t'(req.action) == ACT_READ)) begin
          state_next = ST_READ;
        end
      end
      ST_SWEEP: begin
        if (sw_sts.done) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sw_ctl.start = accept && is_sweep;
    sw_ctl.mode  = SW_CLEAR;
    sw_chr       = background_char;
    if (action_t'(req.action) == ACT_DRAW) begin
      sw_ctl.mode = (req.shape_type == TYPE_FILLED) ? SW_FILL : SW_OUTLINE;
      sw_chr      = req.paint_char;
    end
    rd_en      = accept && (action_t'(req.action) == ACT_READ);
    load_imm   = accept && immediate;
    load_read  = (state == ST_READ);
    load_sweep = (state == ST_SWEEP) && sw_sts.done;
  end

  assign rd_addr = {RW'(req.read_row), CW'(req.read_col)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_imm || load_read || load_sweep) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ok <= rd_in_range;
    end
    if (load_imm) begin
      rsp_status <= draw_bad;
      rsp_cell   <= '0;
    end else if (load_read) begin
      rsp_status <= 1'b0;
      rsp_cell   <= rd_ok ? rd_data : '0;
    end else if (load_sweep) begin
      rsp_status <= 1'b0;
      rsp_cell   <= '0;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.cell_char = rsp_cell;

  rrc_sweep #(
    .MAX_COLS  (MAX_COLS),
    .MAX_ROWS  (MAX_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sweep (
    .clk         (clk),
    .rst         (rst),
    .ctl         (sw_ctl),
    .sts         (sw_sts),
    .rect_left   (req.rect_left),
    .rect_top    (req.rect_top),
    .rect_width  (req.rect_width),
    .rect_height (req.rect_height),
    .chr         (sw_chr),
    .cols        (cols),
    .rows        (rows),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  rrc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (2 ** AW)
  ) u_canvas (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// File: rtl/rrc_ram.sv
module rrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/rrc_sweep.sv
module rrc_sweep #(
  parameter int MAX_COLS  = 256,
  parameter int MAX_ROWS  = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rrc_pkg::sweep_ctl_t                    ctl,
  output rrc_pkg::sweep_sts_t                    sts,
  input  logic signed [rrc_pkg::FIELD_W-1:0]     rect_left,
  input  logic signed [rrc_pkg::FIELD_W-1:0]     rect_top,
  input  logic signed [rrc_pkg::FIELD_W-1:0]     rect_width,
  input  logic signed [rrc_pkg::FIELD_W-1:0]     rect_height,
  input  logic [rrc_pkg::CHAR_W-1:0]             chr,
  input  logic [$clog2(MAX_COLS+1)-1:0]          cols,
  input  logic [$clog2(MAX_ROWS+1)-1:0]          rows,
  output logic                                   wr_en,
  output logic [(MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1)
               + (MAX_COLS > 1 ? $clog2(MAX_COLS) : 1)-1:0] wr_addr,
  output logic [rrc_pkg::CHAR_W-1:0]             wr_data
);
  import rrc_pkg::*;

  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int CW  = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int RW  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int PW  = (CNW > RNW ? CNW : RNW) + FRAC_BITS;
  localparam int GW  = (PW > FIELD_W ? PW : FIELD_W) + 3;
  localparam logic signed [GW-1:0] ONE = GW'(1) << FRAC_BITS;

  sweep_mode_t             mode;
  logic [CHAR_W-1:0]       chr_q;
  logic signed [GW-1:0]    xl, xl1, xr1, xr;
  logic signed [GW-1:0]    yt, yt1, yb1, yb;
  logic                    active;
  logic                    done;
  logic [CNW-1:0]          col;
  logic [RNW-1:0]          row;

  logic signed [GW-1:0]    left_x, top_y, right_x, bottom_y;
  logic signed [GW-1:0]    px, py;
  logic                    last_col, last_row, in_rect, edge_hit;

  assign left_x   = GW'(rect_left);
  assign top_y    = GW'(rect_top);
  assign right_x  = left_x + GW'(rect_width);
  assign bottom_y = top_y + GW'(rect_height);

  assign last_col = (col + CNW'(1)) == cols;
  assign last_row = (row + RNW'(1)) == rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        active <= (cols != '0) && (rows != '0);
        done   <= (cols == '0) || (rows == '0);
        col    <= '0;
        row    <= '0;
        mode   <= ctl.mode;
        chr_q  <= chr;
        xl     <= left_x;
        xl1    <= left_x + ONE;
        xr     <= right_x;
        xr1    <= right_x - ONE;
        yt     <= top_y;
        yt1    <= top_y + ONE;
        yb     <= bottom_y;
        yb1    <= bottom_y - ONE;
      end else if (active) begin
        if (last_col) begin
          col <= '0;
          if (last_row) begin
            active <= 1'b0;
            done   <= 1'b1;
          end else begin
            row <= row + RNW'(1);
          end
        end else begin
          col <= col + CNW'(1);
        end
      end
    end
  end

  assign px = $signed(GW'(col) << FRAC_BITS);
  assign py = $signed(GW'(row) << FRAC_BITS);

  assign in_rect  = (px >= xl) && (px <= xr) && (py >= yt) && (py <= yb);
  assign edge_hit = (px < xl1) || (px > xr1) || (py < yt1) || (py > yb1);

  always_comb begin
    unique case (mode)
      SW_CLEAR:   wr_en = active;
      SW_FILL:    wr_en = active && in_rect;
      SW_OUTLINE: wr_en = active && in_rect && edge_hit;
      default:    wr_en = 1'b0;
    endcase
  end

  assign wr_addr  = {row[RW-1:0], col[CW-1:0]};
  assign wr_data  = chr_q;
  assign sts.busy = active;
  assign sts.done = done;

endmodule
